>>> rtl/core/last_n_lines_buffer_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the last-N-lines buffer checker
// Each macro expects signals named clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef LAST_N_LINES_BUFFER_CORE_MACROS_SVH
`define LAST_N_LINES_BUFFER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define LNLB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define LNLB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/lnlb_pkg.sv
// ----------------------------------------------------------------------------
// lnlb_pkg
// Shared sizes, codes and control types of the last-N-lines buffer.
// ----------------------------------------------------------------------------
package lnlb_pkg;

  // Ring geometry
  localparam int LINE_SLOTS     = 128;
  localparam int MAX_LINE_BYTES = 128;

  localparam int SLOT_W      = $clog2(LINE_SLOTS);
  localparam int OFF_W       = $clog2(MAX_LINE_BYTES);
  localparam int CNT_W       = $clog2(LINE_SLOTS + 1);
  localparam int STORE_DEPTH = LINE_SLOTS * (2 ** OFF_W);

  // Field widths
  localparam int BYTE_W = 8;
  localparam int CMD_W  = 2;
  localparam int SHOW_W = 8;

  localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [SHOW_W-1:0] DEFAULT_SHOW = 8'd10;

  // Request kinds
  typedef enum logic [CMD_W-1:0] {
    CMD_BYTE  = 2'd0,
    CMD_END   = 2'd1,
    CMD_DRAIN = 2'd2
  } cmd_t;

  // Controller to datapath
  typedef struct packed {
    logic latch_in;
    logic write_byte;
    logic close_open;
    logic set_window;
    logic read_step;
    logic load_empty;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic draining;
    logic lines_left_zero;
    logic out_free;
  } dp_status_t;

  // Next slot round the ring
  function automatic logic [SLOT_W-1:0] slot_after(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(LINE_SLOTS - 1)) begin
      r = '0;
    end else begin
      r = s + SLOT_W'(1);
    end
    return r;
  endfunction

endpackage

>>> rtl/core/last_n_lines_buffer_core.sv
// ----------------------------------------------------------------------------
// last_n_lines_buffer_core
// Keeps the most recent text lines of a byte stream and plays them back.
// ----------------------------------------------------------------------------
// Slave channel: s_tuser carries the request kind (byte, end, drain) and
// s_tdata the text byte. Bytes are cut into line chunks (ending after a
// newline, or at MAX_LINE_BYTES-1 bytes) and kept in a ring of LINE_SLOTS.
// An end request closes any partial chunk and fixes the playback window to
// the last lines_to_show lines; each drain request then returns one byte on
// the master channel, oldest first, with line-end and final marks, or an
// empty mark once nothing is left. Bytes and ends after the first end are
// dropped silently.
// Timing: one request at a time. After acceptance s_tready stays low in
// WRITE for a byte, CLOSE and WINDOW for an end, READ and EMIT for a drain
// and EMPTY for an empty drain; dropped requests cost nothing. A drain
// result is loaded from EMIT, after the registered read of the two stores,
// or from EMPTY for an empty mark. If the master side stalls, a drain waits
// with its result in hand until the output register frees; the register
// itself holds a finished result while new requests are taken.
// Reset empties the ring and window and sets lines_to_show to 10; stores
// are not cleared, only written entries are ever read.
// ----------------------------------------------------------------------------
module last_n_lines_buffer_core (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_wen,
  input  logic [7:0] cfg_wdata,    // lines_to_show
  // request channel
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,      // in_byte
  input  logic [1:0] s_tuser,      // cmd
  // result channel
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,      // out_byte
  output logic       m_tlast,      // last
  output logic [1:0] m_tuser       // {empty_res, line_end}
);

  lnlb_pkg::ctrl_cmd_t  cmd;
  lnlb_pkg::dp_status_t status;
  logic                 line_end;
  logic                 empty_res;

  // Sequencer
  lnlb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_cmd   (s_tuser),
    .req_ready (s_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // Stores and pointers
  lnlb_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .in_byte      (s_tdata),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_byte     (m_tdata),
    .out_line_end (line_end),
    .out_last     (m_tlast),
    .out_empty    (empty_res)
  );

  assign m_tuser = {empty_res, line_end};

endmodule

>>> rtl/core/lnlb_ram.sv
// ----------------------------------------------------------------------------
// lnlb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lnlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/core/lnlb_ctrl.sv
// ----------------------------------------------------------------------------
// lnlb_ctrl
// Request sequencer: takes one request, steps the datapath through it.
// ----------------------------------------------------------------------------
module lnlb_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic [lnlb_pkg::CMD_W-1:0]    req_cmd,
  output logic                          req_ready,
  input  lnlb_pkg::dp_status_t          status,
  output lnlb_pkg::ctrl_cmd_t           cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_CLOSE,
    ST_WINDOW,
    ST_READ,
    ST_EMIT,
    ST_EMPTY
  } state_t;

  state_t state;
  state_t state_next;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          case (req_cmd)
            lnlb_pkg::CMD_BYTE: begin
              state_next = status.draining ? ST_IDLE : ST_WRITE;
            end
            lnlb_pkg::CMD_END: begin
              state_next = status.draining ? ST_IDLE : ST_CLOSE;
            end
            lnlb_pkg::CMD_DRAIN: begin
              state_next = (status.draining && !status.lines_left_zero) ? ST_READ : ST_EMPTY;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_WRITE:  state_next = ST_IDLE;
      ST_CLOSE:  state_next = ST_WINDOW;
      ST_WINDOW: state_next = ST_IDLE;
      ST_READ:   state_next = ST_EMIT;
      ST_EMIT:   state_next = status.out_free ? ST_IDLE : ST_EMIT;
      ST_EMPTY:  state_next = status.out_free ? ST_IDLE : ST_EMPTY;
      default:   state_next = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Commands to the datapath
  assign req_ready      = (state == ST_IDLE);
  assign cmd.latch_in   = (state == ST_IDLE) && req_valid;
  assign cmd.write_byte = (state == ST_WRITE);
  assign cmd.close_open = (state == ST_CLOSE);
  assign cmd.set_window = (state == ST_WINDOW);
  assign cmd.read_step  = (state == ST_EMIT) && status.out_free;
  assign cmd.load_empty = (state == ST_EMPTY) && status.out_free;

endmodule

>>> rtl/core/lnlb_datapath.sv
// ----------------------------------------------------------------------------
// lnlb_datapath
// Line stores, ring pointers, drain window and the output register.
// ----------------------------------------------------------------------------
module lnlb_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [lnlb_pkg::SHOW_W-1:0]   cfg_wdata,
  input  logic [lnlb_pkg::BYTE_W-1:0]   in_byte,
  input  lnlb_pkg::ctrl_cmd_t           cmd,
  output lnlb_pkg::dp_status_t          status,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [lnlb_pkg::BYTE_W-1:0]   out_byte,
  output logic                          out_line_end,
  output logic                          out_last,
  output logic                          out_empty
);

  localparam int SLOT_W = lnlb_pkg::SLOT_W;
  localparam int OFF_W  = lnlb_pkg::OFF_W;
  localparam int CNT_W  = lnlb_pkg::CNT_W;

  // Control registers
  logic [lnlb_pkg::SHOW_W-1:0] lines_to_show;
  logic [SLOT_W-1:0]           next_slot;
  logic [CNT_W-1:0]            lines_seen;
  logic [OFF_W-1:0]            open_len;
  logic                        draining;
  logic [SLOT_W-1:0]           read_slot;
  logic [OFF_W-1:0]            read_offset;
  logic [CNT_W-1:0]            lines_left;

  // Latched request byte
  logic [lnlb_pkg::BYTE_W-1:0] byte_r;

  // Store ports
  logic                        len_wen;
  logic [OFF_W-1:0]            len_wdata;
  logic [OFF_W-1:0]            len_rdata;
  logic [lnlb_pkg::BYTE_W-1:0] byte_rdata;

  // Byte write: length after this byte, and whether the chunk closes
  logic [OFF_W-1:0] len_inc;
  logic             chunk_full;
  logic             do_close;
  assign len_inc    = open_len + OFF_W'(1);
  assign chunk_full = (byte_r == lnlb_pkg::NEWLINE_CODE) ||
                      (len_inc >= OFF_W'(lnlb_pkg::MAX_LINE_BYTES - 1));
  assign do_close   = (cmd.write_byte && chunk_full) ||
                      (cmd.close_open && (open_len != '0));
  assign len_wen    = do_close;
  assign len_wdata  = cmd.write_byte ? len_inc : open_len;

  // Window start: clamp the register, cap at lines seen, step back round the ring
  logic [lnlb_pkg::SHOW_W-1:0] show_eff;
  logic [CNT_W-1:0]            n_cap;
  logic [CNT_W-1:0]            n_win;
  logic [CNT_W:0]              start_sum;
  logic [SLOT_W-1:0]           start_slot;
  assign show_eff  = (lines_to_show == '0) ? lnlb_pkg::DEFAULT_SHOW : lines_to_show;
  assign n_cap     = (32'(show_eff) > 32'(lnlb_pkg::LINE_SLOTS)) ?
                     CNT_W'(lnlb_pkg::LINE_SLOTS) : CNT_W'(show_eff);
  assign n_win     = (n_cap > lines_seen) ? lines_seen : n_cap;
  assign start_sum = (CNT_W+1)'(next_slot) + (CNT_W+1)'(lnlb_pkg::LINE_SLOTS) -
                     (CNT_W+1)'(n_win);
  assign start_slot = (start_sum >= (CNT_W+1)'(lnlb_pkg::LINE_SLOTS)) ?
                      SLOT_W'(start_sum - (CNT_W+1)'(lnlb_pkg::LINE_SLOTS)) :
                      SLOT_W'(start_sum);

  // Drain: end of chunk when the next offset reaches its length
  logic chunk_end;
  assign chunk_end = ((OFF_W+1)'(read_offset) + (OFF_W+1)'(1)) >= (OFF_W+1)'(len_rdata);

  // Byte store, one region per slot
  lnlb_ram #(
    .WIDTH (lnlb_pkg::BYTE_W),
    .DEPTH (lnlb_pkg::STORE_DEPTH)
  ) u_byte_store (
    .clk     (clk),
    .wr_en   (cmd.write_byte),
    .wr_addr ({next_slot, open_len}),
    .wr_data (byte_r),
    .rd_addr ({read_slot, read_offset}),
    .rd_data (byte_rdata)
  );

  // Chunk lengths, one per slot
  lnlb_ram #(
    .WIDTH (OFF_W),
    .DEPTH (lnlb_pkg::LINE_SLOTS)
  ) u_len_store (
    .clk     (clk),
    .wr_en   (len_wen),
    .wr_addr (next_slot),
    .wr_data (len_wdata),
    .rd_addr (read_slot),
    .rd_data (len_rdata)
  );

  // Status to the controller
  assign status.draining        = draining;
  assign status.lines_left_zero = (lines_left == '0);
  assign status.out_free        = !out_valid || out_ready;

  // Request byte latch
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      byte_r <= in_byte;
    end
  end

  // Register, ring and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      lines_to_show <= lnlb_pkg::DEFAULT_SHOW;
      next_slot     <= '0;
      lines_seen    <= '0;
      open_len      <= '0;
      draining      <= 1'b0;
      read_slot     <= '0;
      read_offset   <= '0;
      lines_left    <= '0;
    end else begin
      if (cfg_wen) begin
        lines_to_show <= cfg_wdata;
      end
      // chunk bookkeeping
      if (do_close) begin
        next_slot <= lnlb_pkg::slot_after(next_slot);
        open_len  <= '0;
        if (lines_seen < CNT_W'(lnlb_pkg::LINE_SLOTS)) begin
          lines_seen <= lines_seen + CNT_W'(1);
        end
      end else if (cmd.write_byte) begin
        open_len <= len_inc;
      end
      // fix the window
      if (cmd.set_window) begin
        read_slot   <= start_slot;
        read_offset <= '0;
        lines_left  <= n_win;
        draining    <= 1'b1;
      end
      // advance the read pointer
      if (cmd.read_step) begin
        if (chunk_end) begin
          read_slot   <= lnlb_pkg::slot_after(read_slot);
          read_offset <= '0;
          lines_left  <= lines_left - CNT_W'(1);
        end else begin
          read_offset <= read_offset + OFF_W'(1);
        end
      end
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.read_step || cmd.load_empty) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (cmd.read_step) begin
      out_byte     <= byte_rdata;
      out_line_end <= chunk_end;
      out_last     <= chunk_end && (lines_left == CNT_W'(1));
      out_empty    <= 1'b0;
    end else if (cmd.load_empty) begin
      out_byte     <= '0;
      out_line_end <= 1'b0;
      out_last     <= 1'b0;
      out_empty    <= 1'b1;
    end
  end

endmodule

>>> rtl/core/lnlb_checker.sv
// ----------------------------------------------------------------------------
// lnlb_checker
// Port-level checks of the last-N-lines buffer result channel.
// ----------------------------------------------------------------------------
`include "last_n_lines_buffer_core_macros.svh"

module lnlb_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic [1:0] m_tuser
);

  // Stalled result holds
  `LNLB_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed under stall")

  // Empty mark carries no byte and no marks
  `LNLB_ASSERT_NOW(a_empty, m_tvalid && m_tuser[1], (m_tdata == 8'd0) && !m_tlast && !m_tuser[0], "empty result with payload")

  // Final byte always ends a line
  `LNLB_ASSERT_NOW(a_last, m_tvalid && m_tlast, m_tuser[0] && !m_tuser[1], "final byte without line end")

endmodule

bind last_n_lines_buffer_core lnlb_checker u_lnlb_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
